FILE: src/spta_pkg.sv
// Package with types and constants shared by the sparse polynomial term adder.
`timescale 1ns / 1ps
package spta_pkg;

    // Table size and the number of exponent bits kept in each cell.
    localparam int MAX_TERMS = 64;
    localparam int EXP_BITS  = 10;

    // Field widths fixed by the interface.
    localparam int IN_COEF_W  = 16;
    localparam int IN_EXP_W   = 10;
    localparam int SUM_COEF_W = 22;
    localparam int CNT_W      = $clog2(MAX_TERMS + 1);

    // One input request: a polynomial term.
    typedef struct packed {
        logic signed [IN_COEF_W-1:0] coefficient;
        logic        [IN_EXP_W-1:0]  exponent;
        logic                        final_term;
    } t_in;

    // One result request: a summed term.
    typedef struct packed {
        logic signed [SUM_COEF_W-1:0] sum_coefficient;
        logic        [IN_EXP_W-1:0]   sum_exponent;
        logic                         last_result;
        logic                         overflow;
    } t_out;

    // Contents of one cell of the sorted chain.
    typedef struct packed {
        logic                         valid;
        logic        [EXP_BITS-1:0]   exp;
        logic signed [SUM_COEF_W-1:0] coef;
    } t_cell_data;

    // Term broadcast to all cells on insertion.
    typedef struct packed {
        logic        [EXP_BITS-1:0]  exp;
        logic signed [IN_COEF_W-1:0] coef;
    } t_term;

    // Control sent from the sequencer to every cell.
    typedef struct packed {
        logic clr;
        logic shift;
        logic ins;
        logic any_eq;
    } t_cell_ctl;

endpackage

FILE: src/spta_cell.sv
// One cell of the sorted insertion chain: holds a term; clears, shifts, inserts or merges.
`timescale 1ns / 1ps
module spta_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spta_pkg::t_cell_ctl  i_ctl,
    input  spta_pkg::t_term      i_term,
    input  spta_pkg::t_cell_data i_left,
    input  logic                i_left_before,
    input  spta_pkg::t_cell_data i_right,
    output spta_pkg::t_cell_data o_data,
    output logic                o_before,
    output logic                o_eq,
    output logic                o_nonzero
);
    import spta_pkg::*;

    logic                         r_valid, n_valid;
    logic        [EXP_BITS-1:0]   r_exp, n_exp;
    logic signed [SUM_COEF_W-1:0] r_coef, n_coef;

    // Compare the held term against the broadcast term.
    assign o_before  = r_valid && (r_exp > i_term.exp);
    assign o_eq      = r_valid && (r_exp == i_term.exp);
    assign o_nonzero = r_valid && (r_coef != '0);
    assign o_data    = '{valid: r_valid, exp: r_exp, coef: r_coef};

    // Next contents: clear, shift toward the head, or sorted insert/merge.
    always_comb begin
        n_valid = r_valid;
        n_exp   = r_exp;
        n_coef  = r_coef;
        priority if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_valid = i_right.valid;
            n_exp   = i_right.exp;
            n_coef  = i_right.coef;
        end else if (i_ctl.ins) begin
            if (i_ctl.any_eq) begin
                if (o_eq) begin
                    n_coef = r_coef + SUM_COEF_W'(i_term.coef);
                end
            end else if (!o_before) begin
                if (i_left_before) begin
                    n_valid = 1'b1;
                    n_exp   = i_term.exp;
                    n_coef  = SUM_COEF_W'(i_term.coef);
                end else begin
                    n_valid = i_left.valid;
                    n_exp   = i_left.exp;
                    n_coef  = i_left.coef;
                end
            end
        end
    end

    // Valid flag is reset; the term payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp  <= n_exp;
        r_coef <= n_coef;
    end

endmodule

FILE: src/sparse_polynomial_term_adder_top.sv
// Top level: term intake, sorted cell chain and result drain sequencer.
// Loading: one term accepted per cycle; each is merged or inserted, or dropped once MAX_TERMS are taken.
// After the final term the chain drains one cell per cycle toward the head while the
// output is free; no term is taken meanwhile.
// Results are registered from the head cell; cancelled sums there are shifted out unsent.
// Synchronous active-low reset empties the chain at once; no clearing pass.
`timescale 1ns / 1ps
module sparse_polynomial_term_adder_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  spta_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output spta_pkg::t_out  o_out
);
    import spta_pkg::*;

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             r_emitted, n_emitted;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    t_cell_ctl             ctl;
    t_term                 term;
    t_cell_data            cell_q  [MAX_TERMS];
    t_cell_data            left_d  [MAX_TERMS];
    t_cell_data            right_d [MAX_TERMS];
    logic [MAX_TERMS-1:0]  before_vec, left_before, eq_vec, nz_vec;
    logic                  accept, room, out_free;

    assign o_in_ready  = (r_state == ST_LOAD);
    assign accept      = i_in_valid && o_in_ready;
    assign room        = (r_count < CNT_W'(MAX_TERMS));
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Term broadcast, with the exponent cast to the kept bits (both widths are 10 bits).
    assign term = '{exp: EXP_BITS'(i_in.exponent), coef: i_in.coefficient};

    // Chain of cells; cell 0 holds the largest exponent.
    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign left_d[g]      = '0;
            assign left_before[g] = 1'b1;
        end else begin : g_body
            assign left_d[g]      = cell_q[g-1];
            assign left_before[g] = before_vec[g-1];
        end
        if (g == MAX_TERMS - 1) begin : g_tail
            assign right_d[g] = '0;
        end else begin : g_inner
            assign right_d[g] = cell_q[g+1];
        end
        spta_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_term        (term),
            .i_left        (left_d[g]),
            .i_left_before (left_before[g]),
            .i_right       (right_d[g]),
            .o_data        (cell_q[g]),
            .o_before      (before_vec[g]),
            .o_eq          (eq_vec[g]),
            .o_nonzero     (nz_vec[g])
        );
    end

    // Sequencer: intake while loading, then drain nonzero sums in order, or a lone zero term.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_emitted   = r_emitted;
        n_out       = r_out;
        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;
        ctl         = '0;
        ctl.any_eq  = |eq_vec;
        if (r_state == ST_LOAD) begin
            if (accept) begin
                if (room) begin
                    ctl.ins = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                if (i_in.final_term) begin
                    n_state = ST_DRAIN;
                end
            end
        end else if (out_free) begin
            if (nz_vec == '0) begin
                // Nothing left; emit the zero term if no sum survived.
                if (!r_emitted) begin
                    n_out_valid = 1'b1;
                    n_out       = '{sum_coefficient: '0, sum_exponent: '0,
                                    last_result: 1'b1, overflow: r_ovf};
                end
                ctl.clr   = 1'b1;
                n_state   = ST_LOAD;
                n_count   = '0;
                n_ovf     = 1'b0;
                n_emitted = 1'b0;
            end else if (nz_vec[0]) begin
                n_out_valid = 1'b1;
                n_out       = '{sum_coefficient: cell_q[0].coef,
                                sum_exponent: IN_EXP_W'(cell_q[0].exp),
                                last_result: !(|nz_vec[MAX_TERMS-1:1]),
                                overflow: r_ovf};
                ctl.shift   = 1'b1;
                n_emitted   = 1'b1;
            end else begin
                ctl.shift = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_emitted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_emitted   <= n_emitted;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

FILE: src/spta_checker.sv
// Port-level checker for the sparse polynomial term adder, bound to the top.
`timescale 1ns / 1ps
module spta_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input spta_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input spta_pkg::t_out o_out
);
    import spta_pkg::*;

    // A stalled result request holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result request changed while stalled");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // The final term starts the drain, which takes no further terms.
    a_final_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.final_term |=> !o_in_ready)
        else $error("term accepted right after the final term");

    // A zero sum only appears as the lone closing term with exponent zero.
    a_zero_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.sum_coefficient == '0) |->
            o_out.last_result && (o_out.sum_exponent == '0))
        else $error("zero sum emitted other than as the lone result");

endmodule

bind sparse_polynomial_term_adder_top spta_checker u_spta_checker (.*);

FILE: bench/sparse_polynomial_term_adder_top_test.sv
// Self-checking testbench for the sparse polynomial term adder.
`timescale 1ns / 1ps
module sparse_polynomial_term_adder_top_test;
    import spta_pkg::*;

    // A very slow correct run stays far below this many cycles.
    localparam int LIMIT_CYCLES = 500000;

    // Shapes of a random set of terms.
    typedef enum int {
        STYLE_SPREAD,
        STYLE_CLUSTER,
        STYLE_CANCEL_PAIRS,
        STYLE_EXTREMES
    } t_set_style;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    t_in    i_in;
    logic   o_out_valid;
    logic   i_out_ready;
    t_out   o_out;

    // Terms pooled so far in the current set, as the block should hold them.
    int                  pool_coef[$];
    logic [EXP_BITS-1:0] pool_exp[$];
    bit                  pool_overflow;

    // Summed terms still owed by the block, oldest first.
    t_out expected_terms[$];
    t_out want;

    int errors;
    int items_sent;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    sparse_polynomial_term_adder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        while (cycle_count <= LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
        $display("FAIL");
        $finish;
    end

    // Receiver: ready drops at random according to the stall rate.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sum every exponent group of the pool and queue the nonzero sums, highest exponent first.
    function automatic void sum_pooled_terms();
        bit                  taken[MAX_TERMS];
        t_out                sums[$];
        t_out                r;
        int                  best;
        int                  sum;
        logic [EXP_BITS-1:0] e;
        for (int i = 0; i < MAX_TERMS; i++) taken[i] = 1'b0;
        do begin
            best = -1;
            for (int i = 0; i < pool_coef.size(); i++) begin
                if (!taken[i] && (best < 0 || pool_exp[i] > pool_exp[best])) best = i;
            end
            if (best >= 0) begin
                e   = pool_exp[best];
                sum = 0;
                for (int i = 0; i < pool_coef.size(); i++) begin
                    if (!taken[i] && pool_exp[i] == e) begin
                        sum += pool_coef[i];
                        taken[i] = 1'b1;
                    end
                end
                if (sum != 0) begin
                    r.sum_coefficient = SUM_COEF_W'(sum);
                    r.sum_exponent    = IN_EXP_W'(e);
                    r.last_result     = 1'b0;
                    r.overflow        = pool_overflow;
                    sums.push_back(r);
                end
            end
        end while (best >= 0);
        // Everything cancelled: a single zero term stands for the result.
        if (sums.size() == 0) begin
            r             = '0;
            r.last_result = 1'b1;
            r.overflow    = pool_overflow;
            sums.push_back(r);
        end else begin
            r             = sums.pop_back();
            r.last_result = 1'b1;
            sums.push_back(r);
        end
        foreach (sums[k]) expected_terms.push_back(sums[k]);
        pool_coef.delete();
        pool_exp.delete();
        pool_overflow = 1'b0;
    endfunction

    // Pool one accepted term; a full table drops it and remembers the overflow.
    function automatic void pool_term(input t_in term);
        if (pool_coef.size() < MAX_TERMS) begin
            pool_coef.push_back(int'($signed(term.coefficient)));
            pool_exp.push_back(term.exponent[EXP_BITS-1:0]);
        end else begin
            pool_overflow = 1'b1;
        end
        if (term.final_term) sum_pooled_terms();
    endfunction

    // Offer one term request and return at the edge that accepts it.
    task automatic send_term(input t_in term);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= term;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pool_term(term);
        items_sent++;
    endtask

    task automatic send_fields(input int coef, input int expo, input bit fin);
        t_in term;
        term.coefficient = IN_COEF_W'(coef);
        term.exponent    = IN_EXP_W'(expo);
        term.final_term  = fin;
        send_term(term);
    endtask

    // Drop valid, wait for every owed result, then let the block settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_terms.size() != 0) @(posedge i_clk);
        repeat (MAX_TERMS + 4) @(posedge i_clk);
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_terms.size() == 0) begin
                $display("%0t: result with nothing expected: coef %0d exp %0d last %0b ovf %0b",
                         $time, o_out.sum_coefficient, o_out.sum_exponent,
                         o_out.last_result, o_out.overflow);
                errors++;
            end else begin
                want = expected_terms.pop_front();
                if (o_out !== want) begin
                    $display({"%0t: result mismatch: expected coef %0d exp %0d last %0b ovf %0b,",
                              " got coef %0d exp %0d last %0b ovf %0b"},
                             $time, want.sum_coefficient, want.sum_exponent,
                             want.last_result, want.overflow, o_out.sum_coefficient,
                             o_out.sum_exponent, o_out.last_result, o_out.overflow);
                    errors++;
                end
            end
        end
    end

    // Field extremes, single terms, cancellation and merging with ordering.
    task automatic test_directed_sets();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_fields(0, 1023, 1'b1);
        send_fields(32767, 1023, 1'b1);
        send_fields(-32768, 0, 1'b1);
        send_fields(5, 7, 1'b0);
        send_fields(-5, 7, 1'b1);
        send_fields(3, 2, 1'b0);
        send_fields(4, 9, 1'b0);
        send_fields(-1, 2, 1'b0);
        send_fields(7, 0, 1'b0);
        send_fields(2, 5, 1'b0);
        send_fields(-4, 9, 1'b0);
        send_fields(1, 1023, 1'b1);
        send_fields(-1, 1, 1'b1);
        send_fields(1, 0, 1'b0);
        send_fields(1, 0, 1'b0);
        send_fields(1, 0, 1'b1);
        send_fields(-32768, 512, 1'b0);
        send_fields(32767, 511, 1'b1);
        drain_results();
    endtask

    // Full table: largest sums of both signs and terms dropped past capacity.
    task automatic test_full_table();
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        for (int k = 0; k < MAX_TERMS; k++) send_fields(32767, 1023, k == MAX_TERMS - 1);
        for (int k = 0; k < MAX_TERMS; k++) send_fields(-32768, 0, k == MAX_TERMS - 1);
        // Cancelling pairs and two surviving terms fill the table; the extra
        // terms, the final mark among them, are dropped.
        for (int k = 0; k < MAX_TERMS / 2 - 1; k++) begin
            send_fields(k + 100, k, 1'b0);
            send_fields(-(k + 100), k, 1'b0);
        end
        send_fields(9, 3, 1'b0);
        send_fields(-7, 40, 1'b0);
        for (int k = 0; k < 6; k++) begin
            send_fields(int'($signed(16'($urandom))), $urandom_range(15), k == 5);
        end
        drain_results();
    endtask

    // One set of terms of a random style, ending with the final mark.
    task automatic send_random_set(input int n_terms);
        t_in                   term;
        t_set_style            style;
        logic [IN_EXP_W-1:0]   base;
        logic signed [15:0]    prev_coef;
        logic [IN_EXP_W-1:0]   prev_exp;
        style     = t_set_style'($urandom_range(3));
        base      = IN_EXP_W'($urandom);
        prev_coef = '0;
        prev_exp  = '0;
        for (int k = 0; k < n_terms; k++) begin
            term.coefficient = IN_COEF_W'($urandom);
            term.exponent    = IN_EXP_W'($urandom);
            case (style)
                STYLE_CLUSTER: begin
                    term.exponent = base + IN_EXP_W'($urandom_range(3));
                end
                STYLE_CANCEL_PAIRS: begin
                    if (k % 2 == 1) begin
                        term.coefficient = -prev_coef;
                        term.exponent    = prev_exp;
                    end else if (term.coefficient == 16'sh8000) begin
                        term.coefficient = 16'sh7fff;
                    end
                end
                STYLE_EXTREMES: begin
                    case ($urandom_range(4))
                        0: term.coefficient = 16'sh7fff;
                        1: term.coefficient = 16'sh8000;
                        2: term.coefficient = 16'sh0001;
                        3: term.coefficient = 16'shffff;
                        default: term.coefficient = '0;
                    endcase
                    case ($urandom_range(2))
                        0: term.exponent = '0;
                        1: term.exponent = '1;
                        default: term.exponent = base;
                    endcase
                end
                default: begin
                end
            endcase
            prev_coef       = term.coefficient;
            prev_exp        = term.exponent;
            // An occasional early final mark splits the set.
            term.final_term = (k == n_terms - 1) || ($urandom_range(19) == 0);
            send_term(term);
        end
    endtask

    // Random sets under one idling setting; mostly small, a few past capacity.
    task automatic run_random_phase(input int send_pct, input int recv_pct);
        int goal;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        goal           = items_sent + 40;
        while (items_sent < goal) begin
            if ($urandom_range(11) == 0) send_random_set($urandom_range(60, 68));
            else send_random_set($urandom_range(1, 12));
        end
        drain_results();
    endtask

    task automatic test_random_sets();
        run_random_phase(0, 0);
        run_random_phase(54, 0);
        run_random_phase(0, 54);
        run_random_phase(30, 30);
    endtask

    // Test sequence.
    initial begin
        errors         = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pool_overflow  = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_sets();
        test_full_table();
        test_random_sets();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/spta_pkg.sv
src/spta_cell.sv
src/sparse_polynomial_term_adder_top.sv
src/spta_checker.sv
bench/sparse_polynomial_term_adder_top_test.sv
